### sv/cda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and calendar tables for the date arithmetic block.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 23;
  localparam int unsigned DistW  = 22;
  localparam int unsigned DbmW   = 9;
  localparam int unsigned QuotW  = 8;
  localparam int unsigned ProdW  = 27;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 56;

  // Division by 100 for values below 2^14 as a reciprocal multiply.
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int unsigned RecipShift = 19;

  localparam logic [1:0] OrdEqual   = 2'b00;
  localparam logic [1:0] OrdLater   = 2'b01;
  localparam logic [1:0] OrdEarlier = 2'b11;

  localparam logic [MonW-1:0] MonFeb = 4'd2;
  localparam logic [MonW-1:0] MonMar = 4'd3;
  localparam logic [MonW-1:0] MonApr = 4'd4;
  localparam logic [MonW-1:0] MonJun = 4'd6;
  localparam logic [MonW-1:0] MonSep = 4'd9;
  localparam logic [MonW-1:0] MonNov = 4'd11;
  localparam logic [MonW-1:0] MonDec = 4'd12;

  localparam logic [DistW-1:0] DistMax = '1;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              ok;
    logic [DayW-1:0]   len;
    logic [DayW-1:0]   day;
    logic [MonW-1:0]   month;
    logic [YearW-1:0]  year;
  } date_info_t;

  function automatic logic [DbmW-1:0] days_before(input logic [MonW-1:0] m);
    logic [DbmW-1:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      4'd13:   r = 9'd365;
      4'd14:   r = 9'd396;
      4'd15:   r = 9'd427;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] r;
    if (m == MonApr || m == MonJun || m == MonSep || m == MonNov) begin
      r = 5'd30;
    end else if (m == MonFeb) begin
      r = leap ? 5'd29 : 5'd28;
    end else begin
      r = 5'd31;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/cda_date_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_date_pipe
// Three-stage pipeline that turns one date into its day count, its month
// length and a validity flag.
// ----------------------------------------------------------------------------
module cda_date_pipe #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                             clk_i,
  input  cda_pkg::stage_en_t               en_i,
  input  logic [cda_pkg::DayW-1:0]         day_i,
  input  logic [cda_pkg::MonW-1:0]         month_i,
  input  logic [cda_pkg::YearW-1:0]        year_i,
  output cda_pkg::date_info_t              info_o
);
  import cda_pkg::*;

  localparam logic [15:0] MaxYear = 16'(MAX_YEAR);

  logic [YearW-1:0]  n_s0;
  logic [ProdW-1:0]  prod_n;
  logic [ProdW-1:0]  prod_y;

  logic [DayW-1:0]   day1_q;
  logic [MonW-1:0]   mon1_q;
  logic [YearW-1:0]  year1_q;
  logic [YearW-1:0]  n1_q;
  logic [QuotW-1:0]  qn1_q;
  logic [QuotW-1:0]  qy1_q;

  logic [YearW-1:0]  rem100;
  logic              leap;
  logic [DayW-1:0]   len_s1;
  logic [CountW-1:0] ydays_s1;
  logic [DbmW-1:0]   dbm_s1;
  logic              ok_s1;

  logic [DayW-1:0]   day2_q;
  logic [MonW-1:0]   mon2_q;
  logic [YearW-1:0]  year2_q;
  logic [CountW-1:0] ydays2_q;
  logic [DbmW-1:0]   dbm2_q;
  logic [DayW-1:0]   len2_q;
  logic              ok2_q;

  // Stage 1: years before this one and the quotients by 100.
  assign n_s0   = (year_i == '0) ? '0 : year_i - 14'd1;
  assign prod_n = ProdW'(n_s0) * ProdW'(Recip100);
  assign prod_y = ProdW'(year_i) * ProdW'(Recip100);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      day1_q  <= day_i;
      mon1_q  <= month_i;
      year1_q <= year_i;
      n1_q    <= n_s0;
      qn1_q   <= prod_n[RecipShift +: QuotW];
      qy1_q   <= prod_y[RecipShift +: QuotW];
    end
  end

  // Stage 2: leap rule, whole-year days, days before the month and validity.
  assign rem100   = year1_q - YearW'(qy1_q) * YearW'(100);
  assign leap     = ((year1_q[1:0] == 2'b00) && (rem100 != '0)) ||
                    ((rem100 == '0) && (qy1_q[1:0] == 2'b00));
  assign len_s1   = month_len(mon1_q, leap);
  assign ydays_s1 = CountW'(n1_q) * CountW'(365) + CountW'(n1_q >> 2)
                  - CountW'(qn1_q) + CountW'(qn1_q >> 2);
  assign dbm_s1   = days_before(mon1_q) + DbmW'((mon1_q >= MonMar) && leap);
  assign ok_s1    = (year1_q != '0) && ({2'b00, year1_q} <= MaxYear) &&
                    (mon1_q != '0) && (mon1_q <= MonDec) &&
                    (day1_q != '0) && (day1_q <= len_s1);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      day2_q   <= day1_q;
      mon2_q   <= mon1_q;
      year2_q  <= year1_q;
      ydays2_q <= ydays_s1;
      dbm2_q   <= dbm_s1;
      len2_q   <= len_s1;
      ok2_q    <= ok_s1;
    end
  end

  // Stage 3: total day count.
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      info_o.count <= ydays2_q + CountW'(dbm2_q) + CountW'(day2_q);
      info_o.ok    <= ok2_q;
      info_o.len   <= len2_q;
      info_o.day   <= day2_q;
      info_o.month <= mon2_q;
      info_o.year  <= year2_q;
    end
  end

endmodule
`default_nettype wire

### sv/calendar_date_arithmetic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_arithmetic
// Checks two Gregorian dates, orders them, gives their distance in days and
// the date after the first one.
//
//   Bus      Dir   Width  Contents
//   s_axis   in    48     day_a, month_a, year_a, day_b, month_b, year_b
//   m_axis   out   56     valid_a, valid_b, order, day_distance, next_day,
//                         next_month, next_year
//
// One beat enters per cycle while the output is not stalled.
// The four stages are the quotient multiplies, the leap and year sums,
// the day count sum, and the distance with the next date.
// Each stage moves on when it is empty or the stage after it moves, so
// bubbles fill and a stall holds every beat in place.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // day_a, month_a, year_a, day_b, month_b, year_b, zero pad
  input  logic [cda_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // valid_a, valid_b, order, day_distance, next_day, next_month, next_year, zero pad
  output logic [cda_pkg::OutDataW-1:0]    m_axis_tdata
);
  import cda_pkg::*;

  logic [DayW-1:0]    day_a;
  logic [MonW-1:0]    mon_a;
  logic [YearW-1:0]   year_a;
  logic [DayW-1:0]    day_b;
  logic [MonW-1:0]    mon_b;
  logic [YearW-1:0]   year_b;

  logic               v1_q, v2_q, v3_q, v4_q;
  logic               rdy1, rdy2, rdy3, rdy4;
  stage_en_t          en;

  logic [22:0]        key_a, key_b;
  logic [1:0]         ord_s0;
  logic [1:0]         ord1_q, ord2_q, ord3_q;

  date_info_t         info_a, info_b;

  logic [CountW-1:0]  diff;
  logic [DistW-1:0]   dist_s3;
  logic [DayW-1:0]    nd_s3;
  logic [4:0]         nm_s3;
  logic [YearW-1:0]   ny_s3;

  logic               valid_a_q, valid_b_q;
  logic [1:0]         order_q;
  logic [DistW-1:0]   dist_q;
  logic [DayW-1:0]    nd_q;
  logic [4:0]         nm_q;
  logic [YearW-1:0]   ny_q;

  assign day_a  = s_axis_tdata[4:0];
  assign mon_a  = s_axis_tdata[8:5];
  assign year_a = s_axis_tdata[22:9];
  assign day_b  = s_axis_tdata[27:23];
  assign mon_b  = s_axis_tdata[31:28];
  assign year_b = s_axis_tdata[45:32];

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  assign key_a  = {year_a, mon_a, day_a};
  assign key_b  = {year_b, mon_b, day_b};
  assign ord_s0 = (key_a == key_b) ? OrdEqual : ((key_a > key_b) ? OrdLater : OrdEarlier);

  always_ff @(posedge clk_i) begin
    if (rdy1) ord1_q <= ord_s0;
    if (rdy2) ord2_q <= ord1_q;
    if (rdy3) ord3_q <= ord2_q;
  end

  cda_date_pipe #(
    .MAX_YEAR (MAX_YEAR)
  ) u_pipe_a (
    .clk_i   (clk_i),
    .en_i    (en),
    .day_i   (day_a),
    .month_i (mon_a),
    .year_i  (year_a),
    .info_o  (info_a)
  );

  cda_date_pipe #(
    .MAX_YEAR (MAX_YEAR)
  ) u_pipe_b (
    .clk_i   (clk_i),
    .en_i    (en),
    .day_i   (day_b),
    .month_i (mon_b),
    .year_i  (year_b),
    .info_o  (info_b)
  );

  assign diff    = (info_a.count > info_b.count) ? info_a.count - info_b.count
                                                 : info_b.count - info_a.count;
  assign dist_s3 = diff[CountW-1] ? DistMax : diff[DistW-1:0];

  always_comb begin
    if (info_a.day < info_a.len) begin
      nd_s3 = info_a.day + 5'd1;
      nm_s3 = {1'b0, info_a.month};
      ny_s3 = info_a.year;
    end else if (info_a.month == MonDec) begin
      nd_s3 = 5'd1;
      nm_s3 = 5'd1;
      ny_s3 = info_a.year + 14'd1;
    end else begin
      nd_s3 = 5'd1;
      nm_s3 = {1'b0, info_a.month} + 5'd1;
      ny_s3 = info_a.year;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      valid_a_q <= info_a.ok;
      valid_b_q <= info_b.ok;
      order_q   <= ord3_q;
      dist_q    <= dist_s3;
      nd_q      <= nd_s3;
      nm_q      <= nm_s3;
      ny_q      <= ny_s3;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {6'b0, ny_q, nm_q, nd_q, dist_q, order_q, valid_b_q, valid_a_q};

endmodule
`default_nettype wire

### sv/cda_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_checker
// Port-level checks for the date arithmetic block, bound to the top level.
// ----------------------------------------------------------------------------
module cda_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  input  wire logic [cda_pkg::OutDataW-1:0] m_axis_tdata
);
  import cda_pkg::*;

  // A stalled output beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its data.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  // The order field never carries the unused code.
  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:2] != 2'b10)
    else $error("order field holds an unused code");

  // Equal dates are zero days apart.
  a_equal_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:2] == OrdEqual |-> m_axis_tdata[25:4] == '0)
    else $error("equal dates with nonzero distance");

  // The date after a valid date has a real month and a nonzero day.
  a_next_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      m_axis_tdata[35:31] != 5'd0 && m_axis_tdata[35:31] <= 5'd12 &&
      m_axis_tdata[30:26] != 5'd0)
    else $error("next date of a valid date is out of range");

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
